@@ rtl/assert_macros.svh @@
// Assertion helpers shared by several RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BRA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bond risk analytics: check failed");

// Next-cycle implication, disabled while reset is active.
`define BRA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bond risk analytics: check failed");

`endif

@@ rtl/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// bra_pkg
// Types, constants and fixed-point helpers for the bond risk analytics block.
// ----------------------------------------------------------------------------
package bra_pkg;

	// Fixed scale factors of the analytics
	localparam logic [63:0] RATE_DEN     = 64'd200000;
	localparam logic [63:0] COUPON_DEN   = 64'd2000;
	localparam logic [63:0] REDEEM       = 64'd100;
	localparam logic [63:0] PRICE_SCALE  = 64'd1000000;
	localparam logic [63:0] PRICE_MAX    = 64'd1000000000;
	localparam logic [63:0] DUR_SCALE    = 64'd5000000000;
	localparam logic [63:0] DUR_MAX      = 64'd200000000;
	localparam logic [63:0] CONV_SCALE   = 64'd1000000000000;
	localparam logic [63:0] CONV_MAX     = 64'd1000000000;
	localparam logic [63:0] VALUE_MAX    = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] DV01_MAX     = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic signed [18:0] BUMP_MILLI = 19'sd10;

	// Shared arithmetic unit
	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} bra_astate_t;
	typedef enum logic {OP_MUL, OP_DIV} bra_aop_t;

	typedef struct packed {
		logic     start;
		bra_aop_t op;
	} bra_areq_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bra_asts_t;

	// One classified bond, as queued between front and back
	typedef struct packed {
		logic [14:0]        coupon;
		logic signed [15:0] ymilli;
		logic signed [17:0] shock_milli;
		logic [7:0]         periods;
		logic [44:0]        fu;
		logic               short_pos;
	} bra_job_t;

	// Back-end sequencer
	typedef enum logic [3:0] {
		B_IDLE, B_CDIV, B_DDIV, B_LOOP, B_MDF, B_MPV, B_ACC, B_MFIN, B_NEXT,
		B_POST, B_OUT
	} bra_bstate_t;

	typedef enum logic [2:0] {
		PS_PRICE, PS_MV, PS_DV01, PS_PNL, PS_DURM, PS_DURD, PS_CONVM, PS_CONVD
	} bra_post_t;

	// round(p / 2^sh), saturating at 64 bits
	function automatic logic [63:0] mul_round(input logic [127:0] p, input int unsigned sh);
		logic [128:0] s;
		logic [128:0] t;
		s = {1'b0, p} + (129'd1 << (sh - 1));
		t = s >> sh;
		return (|t[128:64]) ? '1 : t[63:0];
	endfunction

	// Saturating 64-bit add
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// Signed pack of a magnitude, clamped to the output range
	function automatic logic [63:0] pack_signed(input logic neg, input logic [63:0] mag,
			input logic [63:0] maxpos);
		logic [63:0] m;
		if (neg) begin
			m = (mag > maxpos + 64'd1) ? maxpos + 64'd1 : mag;
			return 64'd0 - m;
		end else begin
			return (mag > maxpos) ? maxpos : mag;
		end
	endfunction

endpackage

@@ rtl/bra_front.sv @@
// ----------------------------------------------------------------------------
// bra_front
// Accepts bonds, clamps maturity, forms face times position and the shock.
// ----------------------------------------------------------------------------
module bra_front import bra_pkg::*; #(
	parameter int unsigned MAX_PERIODS = 200
) (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [14:0]        coupon_milli_pct,
	input  logic signed [15:0] yield_milli_pct,
	input  logic [7:0]         half_years,
	input  logic [26:0]        face_amount,
	input  logic signed [17:0] units_held,
	input  logic signed [12:0] shock_bps,
	input  logic               q_full,
	output logic               push,
	output bra_job_t           job
);

	localparam int unsigned PCLAMP = (MAX_PERIODS > 255) ? 255 : MAX_PERIODS;

	logic [17:0]        umag;
	logic signed [17:0] sx;

	// Hold the source while the queue is full
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Classify one bond
	always_comb begin
		umag = units_held[17] ? 18'(-units_held) : 18'(units_held);
		sx   = 18'(shock_bps);
		job.coupon      = coupon_milli_pct;
		job.ymilli      = yield_milli_pct;
		job.shock_milli = (sx <<< 3) + (sx <<< 1);
		job.fu          = 45'(face_amount) * 45'(umag);
		job.short_pos   = units_held[17];
		if (half_years == 8'd0) begin
			job.periods = 8'd1;
		end else if (half_years > PCLAMP[7:0]) begin
			job.periods = PCLAMP[7:0];
		end else begin
			job.periods = half_years;
		end
	end

endmodule

@@ rtl/bra_queue.sv @@
// ----------------------------------------------------------------------------
// bra_queue
// Two-entry queue of classified bonds between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bra_queue import bra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  bra_job_t wr_job,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output bra_job_t rd_job
);

	bra_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	// Store on push
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`BRA_ASSERT_IMP(a_q_count_range, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`BRA_ASSERT_IMP(a_q_pop_nonempty, clk, arst_n, pop, !empty)
	`BRA_ASSERT_IMP(a_q_ptrs_empty, clk, arst_n, cnt_q == 2'd0, wr_ptr_q == rd_ptr_q)

endmodule

@@ rtl/bra_arith.sv @@
// ----------------------------------------------------------------------------
// bra_arith
// Shared unit: 64x64 multiply from four 32x32 partials, and a restoring
// 128/64 divide with round half up, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bra_arith import bra_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  bra_areq_t    req,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output bra_asts_t    sts,
	output logic [127:0] prod,
	output logic [63:0]  quo
);

	bra_astate_t  state_q;
	bra_astate_t  state_d;
	logic [6:0]   cnt_q;
	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [63:0]  den_q;
	logic [63:0]  r_q;
	logic [63:0]  lo_q;
	logic [63:0]  q_q;
	logic [63:0]  pp_q;
	logic [1:0]   sh_q;
	logic [127:0] acc_q;
	logic         div_sat;
	logic [31:0]  xa;
	logic [31:0]  xb;
	logic [64:0]  rs;
	logic         ge;

	assign div_sat = (num[127:64] >= den) || (den == 64'd0);
	assign xa = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign xb = cnt_q[1] ? b_q[63:32] : b_q[31:0];
	assign rs = {r_q, lo_q[63]};
	assign ge = rs >= {1'b0, den_q};
	assign prod = acc_q;
	assign quo  = q_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					if (req.op == OP_MUL) begin
						state_d = A_MUL;
					end else begin
						state_d = div_sat ? A_FIN : A_DIV;
					end
				end
			end
			A_MUL:   if (cnt_q == 7'd4) state_d = A_FIN;
			A_DIV:   if (cnt_q == 7'd64) state_d = A_FIN;
			A_FIN:   state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	// Status
	always_comb begin
		sts.busy = (state_q != A_IDLE);
		sts.done = (state_q == A_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= 7'd0;
		end else begin
			state_q <= state_d;
			if (state_q == A_IDLE) begin
				cnt_q <= 7'd0;
			end else begin
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					a_q   <= a;
					b_q   <= b;
					den_q <= den;
					acc_q <= '0;
					r_q   <= num[127:64];
					lo_q  <= num[63:0];
					q_q   <= (req.op == OP_DIV && div_sat) ? '1 : '0;
				end
			end
			A_MUL: begin
				// Partial product, then accumulate the previous one
				if (cnt_q != 7'd4) begin
					pp_q <= 64'(xa) * 64'(xb);
					sh_q <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
				end
				if (cnt_q != 7'd0) begin
					unique case (sh_q)
						2'd0:    acc_q <= acc_q + {64'd0, pp_q};
						2'd1:    acc_q <= acc_q + {32'd0, pp_q, 32'd0};
						default: acc_q <= acc_q + {pp_q, 64'd0};
					endcase
				end
			end
			A_DIV: begin
				if (cnt_q != 7'd64) begin
					r_q  <= ge ? 64'(rs - {1'b0, den_q}) : rs[63:0];
					lo_q <= {lo_q[62:0], 1'b0};
					q_q  <= {q_q[62:0], ge};
				end else if ((r_q >= den_q - r_q) && (q_q != '1)) begin
					q_q <= q_q + 64'd1;
				end
			end
			default: ;
		endcase
	end

	`BRA_ASSERT_IMP(a_ar_start_idle, clk, arst_n, req.start, state_q == A_IDLE)
	`BRA_ASSERT_IMP(a_ar_rem_below, clk, arst_n, state_q == A_DIV, r_q < den_q)
	`BRA_ASSERT_NXT(a_ar_fin_idle, clk, arst_n, state_q == A_FIN, state_q == A_IDLE)

endmodule

@@ rtl/bra_back.sv @@
// ----------------------------------------------------------------------------
// bra_back
// Sequencer that prices each bond at four yields on the shared unit and
// derives value, duration, convexity, DV01 and shock profit or loss.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bra_back import bra_pkg::*; #(
	parameter int unsigned FRACTION_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  bra_job_t           head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [29:0]        price_micro,
	output logic signed [52:0] market_value_cents,
	output logic [27:0]        duration_micro_years,
	output logic signed [30:0] convexity_ten_thousandths,
	output logic signed [47:0] dv01_cents,
	output logic signed [52:0] shock_pnl_cents
);

	localparam logic [63:0]  ONE      = 64'd1 << FRACTION_BITS;
	localparam logic [127:0] RATE_NUM = 128'(RATE_DEN) << FRACTION_BITS;

	bra_bstate_t  state_q;
	bra_bstate_t  state_d;
	bra_post_t    post_q;
	bra_job_t     job_q;
	logic         issued_q;
	logic [1:0]   k_q;
	logic [7:0]   t_q;
	logic [63:0]  c_q;
	logic [63:0]  d_q;
	logic [63:0]  df_q;
	logic [63:0]  pv_q;
	logic [63:0]  tmp_q;
	logic [63:0]  p_q [4];
	logic [63:0]  dd_q;
	logic [63:0]  ca_q;
	logic [63:0]  cb_q;
	logic [63:0]  v0_q;
	logic         out_valid_q;
	logic         load;

	logic [29:0]  res_price_q;
	logic [52:0]  res_mv_q;
	logic [27:0]  res_dur_q;
	logic [30:0]  res_conv_q;
	logic [47:0]  res_dv_q;
	logic [52:0]  res_pnl_q;

	bra_areq_t    areq;
	bra_asts_t    asts;
	logic [63:0]  op_a;
	logic [63:0]  op_b;
	logic [127:0] op_num;
	logic [63:0]  op_den;
	logic [127:0] aprod;
	logic [63:0]  aquo;

	logic signed [18:0] y_sel;
	logic signed [19:0] den_s;
	logic [63:0]  mr;
	logic [63:0]  pmag;
	logic         pneg;
	logic         p0_zero;

	bra_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.a      (op_a),
		.b      (op_b),
		.num    (op_num),
		.den    (op_den),
		.sts    (asts),
		.prod   (aprod),
		.quo    (aquo)
	);

	assign load    = !out_valid_q || !out_stall;
	assign p0_zero = (p_q[0] == 64'd0);
	assign mr      = mul_round(aprod, FRACTION_BITS);
	assign pneg    = mr < v0_q;
	assign pmag    = pneg ? v0_q - mr : mr - v0_q;

	// Yield of the current pricing pass
	always_comb begin
		unique case (k_q)
			2'd0:    y_sel = 19'(job_q.ymilli);
			2'd1:    y_sel = 19'(job_q.ymilli) + BUMP_MILLI;
			2'd2:    y_sel = 19'(job_q.ymilli) - BUMP_MILLI;
			default: y_sel = 19'(job_q.ymilli) + 19'(job_q.shock_milli);
		endcase
		den_s = 20'sd200000 + 20'(y_sel);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty) state_d = B_CDIV;
			B_CDIV: if (asts.done) state_d = B_DDIV;
			B_DDIV: if (asts.done) state_d = B_LOOP;
			B_LOOP: state_d = (t_q == job_q.periods) ? B_MFIN : B_MDF;
			B_MDF:  if (asts.done) state_d = B_MPV;
			B_MPV:  if (asts.done) state_d = B_ACC;
			B_ACC:  state_d = B_LOOP;
			B_MFIN: if (asts.done) state_d = B_NEXT;
			B_NEXT: state_d = (k_q == 2'd3) ? B_POST : B_DDIV;
			B_POST: begin
				if (asts.done && (post_q == PS_CONVD || (post_q == PS_PNL && p0_zero))) begin
					state_d = B_OUT;
				end
			end
			B_OUT:   if (load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs: queue pop and unit operands
	always_comb begin
		pop        = 1'b0;
		areq.start = 1'b0;
		areq.op    = OP_MUL;
		op_a       = '0;
		op_b       = '0;
		op_num     = '0;
		op_den     = '0;
		unique case (state_q)
			B_IDLE: pop = !q_empty;
			B_CDIV: begin
				areq.start = !issued_q;
				areq.op    = OP_DIV;
				op_num     = 128'(job_q.coupon) << FRACTION_BITS;
				op_den     = COUPON_DEN;
			end
			B_DDIV: begin
				areq.start = !issued_q;
				areq.op    = OP_DIV;
				op_num     = RATE_NUM;
				op_den     = {44'd0, den_s};
			end
			B_MDF: begin
				areq.start = !issued_q;
				op_a       = df_q;
				op_b       = d_q;
			end
			B_MPV: begin
				areq.start = !issued_q;
				op_a       = c_q;
				op_b       = df_q;
			end
			B_MFIN: begin
				areq.start = !issued_q;
				op_a       = df_q;
				op_b       = REDEEM;
			end
			B_POST: begin
				areq.start = !issued_q;
				op_num     = aprod;
				op_den     = p_q[0];
				unique case (post_q)
					PS_PRICE: begin op_a = p_q[0]; op_b = PRICE_SCALE; end
					PS_MV:    begin op_a = p_q[0]; op_b = 64'(job_q.fu); end
					PS_DV01:  begin op_a = dd_q;   op_b = 64'(job_q.fu); end
					PS_PNL:   begin op_a = p_q[3]; op_b = 64'(job_q.fu); end
					PS_DURM:  begin op_a = dd_q;   op_b = DUR_SCALE; end
					PS_CONVM: begin
						op_a = (ca_q < cb_q) ? cb_q - ca_q : ca_q - cb_q;
						op_b = CONV_SCALE;
					end
					default:  areq.op = OP_DIV;
				endcase
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (asts.done) begin
				issued_q <= 1'b0;
			end else if (areq.start) begin
				issued_q <= 1'b1;
			end
			if (state_q == B_OUT && load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					job_q  <= head;
					k_q    <= 2'd0;
					post_q <= PS_PRICE;
				end
			end
			B_CDIV: if (asts.done) c_q <= aquo;
			B_DDIV: begin
				if (asts.done) begin
					d_q  <= aquo;
					df_q <= ONE;
					pv_q <= '0;
					t_q  <= 8'd0;
				end
			end
			B_MDF: if (asts.done) df_q <= mr;
			B_MPV: if (asts.done) tmp_q <= mr;
			B_ACC: begin
				pv_q <= sat_add(pv_q, tmp_q);
				t_q  <= t_q + 8'd1;
			end
			B_MFIN: begin
				if (asts.done) begin
					p_q[k_q] <= sat_add(pv_q, (|aprod[127:64]) ? '1 : aprod[63:0]);
				end
			end
			B_NEXT: begin
				// Spreads for duration and convexity, taken on every pass; valid once all prices exist
				k_q  <= k_q + 2'd1;
				dd_q <= (p_q[2] >= p_q[1]) ? p_q[2] - p_q[1] : '0;
				ca_q <= (p_q[2] >= p_q[0]) ? p_q[2] - p_q[0] : '0;
				cb_q <= (p_q[0] >= p_q[1]) ? p_q[0] - p_q[1] : '0;
			end
			B_POST: begin
				if (asts.done) begin
					post_q <= bra_post_t'(post_q + 3'd1);
					unique case (post_q)
						PS_PRICE: res_price_q <= 30'((mr > PRICE_MAX) ? PRICE_MAX : mr);
						PS_MV: begin
							v0_q     <= mr;
							res_mv_q <= 53'(pack_signed(job_q.short_pos, mr, VALUE_MAX));
						end
						PS_DV01: begin
							res_dv_q <= 48'(pack_signed(job_q.short_pos,
								mul_round(aprod, FRACTION_BITS + 1), DV01_MAX));
						end
						PS_PNL: begin
							res_pnl_q <= 53'(pack_signed(pneg != job_q.short_pos, pmag,
								VALUE_MAX));
							if (p0_zero) begin
								res_dur_q  <= '0;
								res_conv_q <= '0;
							end
						end
						PS_DURD: res_dur_q <= 28'((aquo > DUR_MAX) ? DUR_MAX : aquo);
						PS_CONVD: begin
							res_conv_q <= 31'(pack_signed(ca_q < cb_q, aquo, CONV_MAX));
						end
						default: ;
					endcase
				end
			end
			B_OUT: begin
				if (load) begin
					price_micro               <= res_price_q;
					market_value_cents        <= res_mv_q;
					duration_micro_years      <= res_dur_q;
					convexity_ten_thousandths <= res_conv_q;
					dv01_cents                <= res_dv_q;
					shock_pnl_cents           <= res_pnl_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`BRA_ASSERT_IMP(a_bk_loop_bound, clk, arst_n, state_q == B_LOOP, t_q <= job_q.periods)
	`BRA_ASSERT_NXT(a_bk_issue_wait, clk, arst_n, areq.start && !asts.done, issued_q)
	`BRA_ASSERT_IMP(a_bk_issued_busy, clk, arst_n, issued_q, asts.busy)

endmodule

@@ rtl/bond_risk_analytics.sv @@
// ----------------------------------------------------------------------------
// bond_risk_analytics
// Semiannual bond price, market value, duration, convexity, DV01 and shock
// profit or loss, one bond per transfer.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | coupon, yield, half_years, face, units, shock
//  out     | out_valid/out_stall | price, value, duration, convexity, dv01, pnl
//
// Each item runs four pricing passes of n discount steps, n the clamped
// half-year count, on the one shared multiply and divide unit, and a new
// item leaves the queue only once the last result has been passed on.
// Reset (arst_n, low) empties the queue and idles the sequencer; no sweep.
// Two classified bonds queue ahead of the sequencer, so the input keeps
// taking transfers while a finished result waits under out_stall, until the queue is full.
module bond_risk_analytics import bra_pkg::*; #(
	parameter int unsigned MAX_PERIODS   = 200,
	parameter int unsigned FRACTION_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [14:0]        coupon_milli_pct,
	input  logic signed [15:0] yield_milli_pct,
	input  logic [7:0]         half_years,
	input  logic [26:0]        face_amount,
	input  logic signed [17:0] units_held,
	input  logic signed [12:0] shock_bps,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [29:0]        price_micro,
	output logic signed [52:0] market_value_cents,
	output logic [27:0]        duration_micro_years,
	output logic signed [30:0] convexity_ten_thousandths,
	output logic signed [47:0] dv01_cents,
	output logic signed [52:0] shock_pnl_cents
);

	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	bra_job_t wr_job;
	bra_job_t rd_job;

	bra_front #(
		.MAX_PERIODS (MAX_PERIODS)
	) u_front (
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.coupon_milli_pct (coupon_milli_pct),
		.yield_milli_pct  (yield_milli_pct),
		.half_years       (half_years),
		.face_amount      (face_amount),
		.units_held       (units_held),
		.shock_bps        (shock_bps),
		.q_full           (q_full),
		.push             (push),
		.job              (wr_job)
	);

	bra_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.full   (q_full),
		.empty  (q_empty),
		.rd_job (rd_job)
	);

	bra_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk                       (clk),
		.arst_n                    (arst_n),
		.q_empty                   (q_empty),
		.head                      (rd_job),
		.pop                       (pop),
		.out_valid                 (out_valid),
		.out_stall                 (out_stall),
		.price_micro               (price_micro),
		.market_value_cents        (market_value_cents),
		.duration_micro_years      (duration_micro_years),
		.convexity_ten_thousandths (convexity_ten_thousandths),
		.dv01_cents                (dv01_cents),
		.shock_pnl_cents           (shock_pnl_cents)
	);

endmodule
